### src/alag_pkg.sv
// Shared types, constants and helper functions for the ambient light auto-gain block.
`timescale 1ns / 1ps
package alag_pkg;

  localparam int CNT_W   = 16;   // channel count width
  localparam int LUX_W   = 19;   // lux result width
  localparam int MULT_W  = 7;    // gain factor width
  localparam int CODE_W  = 3;    // sensor gain code width
  localparam int STEP_W  = 3;    // gain step index width
  localparam int RUN_W   = 4;    // low-run counter width
  localparam int CFG_W   = 16;   // widest config register
  localparam int COEF_W  = 20;   // signed Q16 coefficient width
  localparam int ACC_W   = 37;   // signed MAC accumulator width
  localparam int DIV_W   = 10;   // divisor: factor * halves, max 768
  localparam int QUO_W   = 20;   // dividend / quotient width
  localparam int RAT_W   = 21;   // scaled counts in the ratio tests
  localparam int RND_SH  = 15;   // scale shift folded into the division

  localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

  // Q16 coefficients per region
  localparam logic signed [COEF_W-1:0] COEF_R1_A = 20'sd116281;
  localparam logic signed [COEF_W-1:0] COEF_R1_B = 20'sd72476;
  localparam logic signed [COEF_W-1:0] COEF_R2_A = 20'sd280396;
  localparam logic signed [COEF_W-1:0] COEF_R2_B = -20'sd128110;
  localparam logic signed [COEF_W-1:0] COEF_R3_A = 20'sd38837;
  localparam logic signed [COEF_W-1:0] COEF_R3_B = 20'sd7766;

  // config register indexes
  localparam logic [1:0] CFG_HIGH_THR  = 2'd0;
  localparam logic [1:0] CFG_LOW_THR   = 2'd1;
  localparam logic [1:0] CFG_LOW_RUNS  = 2'd2;
  localparam logic [1:0] CFG_INTEG     = 2'd3;

  localparam logic [CFG_W-1:0] RST_HIGH_THR = 16'd52000;
  localparam logic [CFG_W-1:0] RST_LOW_THR  = 16'd1000;
  localparam logic [RUN_W-1:0] RST_LOW_RUNS = 4'd3;
  localparam logic [3:0]       RST_INTEG    = 4'd2;
  localparam logic [3:0]       INTEG_MAX    = 4'd8;

  typedef enum logic [1:0] {
    OUT_LUX     = 2'd0,
    OUT_NO_NEW  = 2'd1,
    OUT_NO_DATA = 2'd2
  } alag_outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATIO,
    ST_MAC,
    ST_DIV,
    ST_DONE
  } alag_state_e;

  typedef struct packed {
    logic                     start;
    logic [CNT_W-1:0]         c0;
    logic [CNT_W-1:0]         c1;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
  } alag_mac_req_t;

  typedef struct packed {
    logic              start;
    logic [QUO_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } alag_div_req_t;

  function automatic logic [MULT_W-1:0] gain_factor(input logic [CODE_W-1:0] code);
    logic [MULT_W-1:0] f;
    case (code)
      3'd0:    f = 7'd1;
      3'd1:    f = 7'd2;
      3'd2:    f = 7'd4;
      3'd3:    f = 7'd8;
      3'd6:    f = 7'd48;
      3'd7:    f = 7'd96;
      default: f = 7'd1;
    endcase
    return f;
  endfunction

  function automatic logic [CODE_W-1:0] step_code(input logic [STEP_W-1:0] step);
    logic [CODE_W-1:0] c;
    case (step)
      3'd0:    c = 3'd0;
      3'd1:    c = 3'd1;
      3'd2:    c = 3'd2;
      3'd3:    c = 3'd3;
      3'd4:    c = 3'd6;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

endpackage

### src/alag_in_if.sv
// Input channel: one two-channel light reading per beat.
`timescale 1ns / 1ps
interface alag_in_if;
  logic        valid;
  logic        ready;
  logic        data_invalid;
  logic        data_new;
  logic [2:0]  measured_gain_code;
  logic [15:0] visible_count;
  logic [15:0] infrared_count;

  modport source (
    output valid, data_invalid, data_new, measured_gain_code, visible_count, infrared_count,
    input  ready
  );
  modport sink (
    input  valid, data_invalid, data_new, measured_gain_code, visible_count, infrared_count,
    output ready
  );
endinterface

### src/alag_out_if.sv
// Output channel: one result per beat.
`timescale 1ns / 1ps
interface alag_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [18:0] lux;
  logic [6:0]  gain_multiplier;
  logic [15:0] visible_echo;
  logic [15:0] infrared_echo;
  logic        gain_write;
  logic [2:0]  new_gain_code;

  modport source (
    output valid, outcome, lux, gain_multiplier, visible_echo, infrared_echo, gain_write,
           new_gain_code,
    input  ready
  );
  modport sink (
    input  valid, outcome, lux, gain_multiplier, visible_echo, infrared_echo, gain_write,
           new_gain_code,
    output ready
  );
endinterface

### src/alag_mac.sv
// Bit-serial multiply-accumulate: a*c0 + b*c1, one count bit per cycle, MSB first.
`timescale 1ns / 1ps
module alag_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  alag_pkg::alag_mac_req_t               req_i,
  output logic                                  done_o,
  output logic signed [alag_pkg::ACC_W-1:0]     acc_o
);
  import alag_pkg::*;

  localparam int BIT_CW = $clog2(CNT_W);

  logic                     busy_q, done_q;
  logic [BIT_CW-1:0]        cnt_q;
  logic [CNT_W-1:0]         c0_q, c1_q;
  logic signed [COEF_W-1:0] a_q, b_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  a_ext, b_ext;

  assign a_ext = ACC_W'(a_q);
  assign b_ext = ACC_W'(b_q);

  always_comb begin
    acc_d = acc_q <<< 1;
    if (c0_q[CNT_W-1]) acc_d = acc_d + a_ext;
    if (c1_q[CNT_W-1]) acc_d = acc_d + b_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == BIT_CW'(CNT_W - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == BIT_CW'(CNT_W - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      c0_q  <= req_i.c0;
      c1_q  <= req_i.c1;
      a_q   <= req_i.coef_a;
      b_q   <= req_i.coef_b;
      acc_q <= '0;
    end else if (busy_q) begin
      c0_q  <= {c0_q[CNT_W-2:0], 1'b0};
      c1_q  <= {c1_q[CNT_W-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;
endmodule

### src/alag_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module alag_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  alag_pkg::alag_div_req_t       req_i,
  output logic                          done_o,
  output logic [alag_pkg::QUO_W-1:0]    quo_o
);
  import alag_pkg::*;

  localparam int QCNT_W = $clog2(QUO_W);

  logic              busy_q, done_q;
  logic [QCNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q;
  logic [QUO_W-1:0]  quo_q;
  logic [DIV_W:0]    trial;
  logic              qbit;

  // remainder stays below the divisor, so it fits DIV_W bits
  always_comb begin
    trial = {rem_q, quo_q[QUO_W-1]};
    qbit  = (trial >= {1'b0, div_q});
    rem_d = qbit ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == QCNT_W'(QUO_W - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == QCNT_W'(QUO_W - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      div_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

### src/ambient_light_autogain_lux_core.sv
// Ambient light auto-gain controller and lux calculator, top level.
// One result beat per input beat. The gain decision and the state update happen
// in the accept cycle; an item that needs no lux goes from the accept straight
// to the done state. A lux item passes the ratio region test, then the bit-serial
// multiply-accumulate (one count bit per cycle over 16 bits) and the radix-2
// divider (one quotient bit per cycle over 20 bits), and is then handed off; an
// item outside the regions skips both, and a non-positive sum skips the divider.
// A new item is taken once the previous one has moved to the output register,
// which holds it until the sink takes it.
`timescale 1ns / 1ps
module ambient_light_autogain_lux_core #(
  parameter int GAIN_STEPS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [alag_pkg::CFG_W-1:0]    cfg_data_i,
  alag_in_if.sink                       in_i,
  alag_out_if.source                    out_o
);
  import alag_pkg::*;

  localparam logic [STEP_W-1:0] TOP_STEP   = STEP_W'(GAIN_STEPS - 1);
  localparam logic [STEP_W-1:0] START_STEP = (TOP_STEP < 3'd3) ? TOP_STEP : 3'd3;

  // config registers
  logic [CFG_W-1:0] hi_thr_q, lo_thr_q;
  logic [RUN_W-1:0] runs_q;
  logic [3:0]       halves_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_thr_q <= RST_HIGH_THR;
      lo_thr_q <= RST_LOW_THR;
      runs_q   <= RST_LOW_RUNS;
      halves_q <= RST_INTEG;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HIGH_THR: hi_thr_q <= cfg_data_i;
        CFG_LOW_THR:  lo_thr_q <= cfg_data_i;
        CFG_LOW_RUNS: runs_q   <= cfg_data_i[RUN_W-1:0];
        CFG_INTEG:    halves_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  alag_state_e state_q, state_d;
  logic        in_fire, out_fire;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // gain control decision on the incoming beat
  logic [STEP_W-1:0] step_q, step_d;
  logic [RUN_W-1:0]  run_q, run_d, run_inc, need;
  logic              wr_d;
  alag_outcome_e     outc_d;

  always_comb begin
    step_d  = step_q;
    run_d   = run_q;
    wr_d    = 1'b0;
    outc_d  = OUT_LUX;
    run_inc = (run_q < RUN_MAX) ? run_q + 1'b1 : run_q;
    need    = (runs_q == '0) ? RUN_W'(1) : runs_q;
    if (in_i.data_invalid) begin
      outc_d = OUT_NO_DATA;
      if (step_q != '0) begin
        run_d  = '0;
        step_d = step_q - 1'b1;
        wr_d   = 1'b1;
      end
    end else if (!in_i.data_new) begin
      outc_d = OUT_NO_NEW;
    end else if (in_i.visible_count > hi_thr_q && step_q != '0) begin
      run_d  = '0;
      step_d = step_q - 1'b1;
      wr_d   = 1'b1;
      outc_d = OUT_NO_DATA;
    end else if (in_i.visible_count < lo_thr_q) begin
      run_d = run_inc;
      if (run_inc >= need && step_q < TOP_STEP) begin
        run_d  = '0;
        step_d = step_q + 1'b1;
        wr_d   = 1'b1;
        outc_d = OUT_NO_DATA;
      end
    end else begin
      run_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= START_STEP;
      run_q  <= '0;
    end else if (in_fire) begin
      step_q <= step_d;
      run_q  <= run_d;
    end
  end

  // item registers
  alag_outcome_e     outc_q;
  logic              wr_q;
  logic [MULT_W-1:0] mult_q;
  logic [CNT_W-1:0]  ch0_q, ch1_q;
  logic [CODE_W-1:0] code_q;
  logic [DIV_W-1:0]  dvsr_q;
  logic [LUX_W-1:0]  lux_q;
  logic [MULT_W-1:0] mult_in;
  logic [3:0]        halves_eff;

  assign mult_in    = gain_factor(in_i.measured_gain_code);
  assign halves_eff = (halves_q == '0 || halves_q > INTEG_MAX) ? RST_INTEG : halves_q;

  // ratio region tests, cross-multiplied
  logic [RAT_W-1:0]         c0_x, c1_x;
  logic                     reg1, reg2, reg3;
  logic signed [COEF_W-1:0] coef_a, coef_b;

  always_comb begin
    c0_x = RAT_W'(ch0_q);
    c1_x = RAT_W'(ch1_q);
    reg1 = (c1_x * RAT_W'(11)) < (c0_x * RAT_W'(9));
    reg2 = (c1_x * RAT_W'(9))  < (c0_x * RAT_W'(16));
    reg3 = (c1_x * RAT_W'(3))  < (c0_x * RAT_W'(17));
    if (reg1) begin
      coef_a = COEF_R1_A;
      coef_b = COEF_R1_B;
    end else if (reg2) begin
      coef_a = COEF_R2_A;
      coef_b = COEF_R2_B;
    end else begin
      coef_a = COEF_R3_A;
      coef_b = COEF_R3_B;
    end
  end

  alag_mac_req_t           mac_req;
  alag_div_req_t           div_req;
  logic                    mac_done, div_done;
  logic signed [ACC_W-1:0] acc;
  logic [QUO_W-1:0]        quo;
  logic                    acc_pos;
  logic [ACC_W-2:0]        rnd_sum;

  // lux = round(2*S / (D * 2^16)) = floor(((S + D*2^14) >> 15) / D)
  assign acc_pos = (acc > 0);
  assign rnd_sum = acc[ACC_W-2:0] + ((ACC_W - 1)'(dvsr_q) << (RND_SH - 1));

  always_comb begin
    state_d          = state_q;
    mac_req.start    = 1'b0;
    mac_req.c0       = ch0_q;
    mac_req.c1       = ch1_q;
    mac_req.coef_a   = coef_a;
    mac_req.coef_b   = coef_b;
    div_req.start    = 1'b0;
    div_req.dividend = rnd_sum[RND_SH +: QUO_W];
    div_req.divisor  = dvsr_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = (outc_d == OUT_LUX) ? ST_RATIO : ST_DONE;
      end
      ST_RATIO: begin
        if (reg3) begin
          mac_req.start = 1'b1;
          state_d       = ST_MAC;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          if (acc_pos) begin
            div_req.start = 1'b1;
            state_d       = ST_DIV;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_o.valid || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      outc_q <= outc_d;
      wr_q   <= wr_d;
      mult_q <= mult_in;
      ch0_q  <= in_i.visible_count;
      ch1_q  <= in_i.infrared_count;
      code_q <= step_code(step_d);
      dvsr_q <= DIV_W'(mult_in) * DIV_W'(halves_eff);
      lux_q  <= '0;
    end else if (state_q == ST_DIV && div_done) begin
      lux_q <= quo[LUX_W-1:0];
    end
  end

  alag_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .acc_o  (acc)
  );

  alag_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // output register
  logic              out_valid_q, out_load;
  alag_outcome_e     out_outc_q;
  logic [LUX_W-1:0]  out_lux_q;
  logic [MULT_W-1:0] out_mult_q;
  logic [CNT_W-1:0]  out_ch0_q, out_ch1_q;
  logic              out_wr_q;
  logic [CODE_W-1:0] out_code_q;

  assign out_fire = out_o.valid && out_o.ready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (out_fire) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_outc_q <= outc_q;
      out_lux_q  <= lux_q;
      out_mult_q <= mult_q;
      out_ch0_q  <= ch0_q;
      out_ch1_q  <= ch1_q;
      out_wr_q   <= wr_q;
      out_code_q <= code_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.outcome         = out_outc_q;
  assign out_o.lux             = out_lux_q;
  assign out_o.gain_multiplier = out_mult_q;
  assign out_o.visible_echo    = out_ch0_q;
  assign out_o.infrared_echo   = out_ch1_q;
  assign out_o.gain_write      = out_wr_q;
  assign out_o.new_gain_code   = out_code_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= TOP_STEP)
    else $error("gain step beyond top");

  a_step_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(step_q))
    else $error("gain step moved without an accepted beat");

  a_write_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_wr_q) |-> (out_outc_q == OUT_NO_DATA))
    else $error("gain write on a beat that is not no-data");

  a_lux_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_lux_q != '0) |-> (out_outc_q == OUT_LUX))
    else $error("nonzero lux on a non-lux beat");

  a_mac_done_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_MAC))
    else $error("MAC finished outside its state");

endmodule

### tb/ambient_light_autogain_lux_core_tb.sv
// Self-checking testbench for the ambient light auto-gain and lux core.
`timescale 1ns / 1ps
module ambient_light_autogain_lux_core_tb;
  import alag_pkg::*;

  localparam int GAIN_STEPS  = 6;
  localparam int TOP_STEP    = GAIN_STEPS - 1;
  localparam int START_STEP  = (TOP_STEP < 3) ? TOP_STEP : 3;
  localparam int HALF_PERIOD = 6;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 60;
  localparam int NUM_PHASES  = 8;

  // gain factor per sensor code, sensor code per gain step
  localparam int unsigned GAIN_FACTOR [8] = '{1, 2, 4, 8, 1, 1, 48, 96};
  localparam bit [CODE_W-1:0] STEP_CODE [6] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd6, 3'd7};

  typedef struct packed {
    logic              invalid;
    logic              fresh;
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  ch0;
    logic [CNT_W-1:0]  ch1;
  } reading_t;

  typedef struct packed {
    alag_outcome_e     outcome;
    logic [LUX_W-1:0]  lux;
    logic [MULT_W-1:0] mult;
    logic [CNT_W-1:0]  vis;
    logic [CNT_W-1:0]  ir;
    logic              wr;
    logic [CODE_W-1:0] code;
  } light_result_t;

  class light_scoreboard;
    bit [CFG_W-1:0]  high_thr;
    bit [CFG_W-1:0]  low_thr;
    bit [3:0]        runs_needed;
    bit [3:0]        integ;
    bit [STEP_W-1:0] gain_step;
    bit [RUN_W-1:0]  low_run;
    light_result_t   expected_q[$];
    int errors;
    int n_results;
    int n_lux;
    int n_writes;

    function new();
      high_thr    = 16'd52000;
      low_thr     = 16'd1000;
      runs_needed = 4'd3;
      integ       = 4'd2;
      gain_step   = STEP_W'(START_STEP);
      low_run     = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_HIGH_THR: high_thr    = val;
        CFG_LOW_THR:  low_thr     = val;
        CFG_LOW_RUNS: runs_needed = val[3:0];
        CFG_INTEG:    integ       = val[3:0];
        default: ;
      endcase
    endfunction

    function bit [LUX_W-1:0] lux_of(bit [CNT_W-1:0] ch0, bit [CNT_W-1:0] ch1,
                                    bit [CODE_W-1:0] code);
      longint unsigned c0, c1, sum, s, d, p, n;
      int unsigned halves;
      c0  = ch0;
      c1  = ch1;
      sum = c0 + c1;
      if (ch0 == 0 && ch1 == 0) return '0;
      halves = integ;
      if (halves < 1 || halves > 8) halves = 2;
      // exact cross-multiplied ratio tests
      if (100 * c1 < 45 * sum) begin
        s = 116281 * c0 + 72476 * c1;
      end else if (100 * c1 < 64 * sum) begin
        p = 280396 * c0;
        n = 128110 * c1;
        if (p <= n) return '0;
        s = p - n;
      end else if (100 * c1 < 85 * sum) begin
        s = 38837 * c0 + 7766 * c1;
      end else begin
        return '0;
      end
      d = longint'(GAIN_FACTOR[code]) * halves * 65536;
      return LUX_W'((4 * s + d) / (2 * d));
    endfunction

    function void note_reading(reading_t r);
      light_result_t e;
      e.outcome = OUT_LUX;
      e.lux     = '0;
      e.wr      = 1'b0;
      if (r.invalid) begin
        e.outcome = OUT_NO_DATA;
        if (gain_step > 0) begin
          low_run = '0;
          gain_step--;
          e.wr = 1'b1;
        end
      end else if (!r.fresh) begin
        e.outcome = OUT_NO_NEW;
      end else if (r.ch0 > high_thr && gain_step > 0) begin
        low_run = '0;
        gain_step--;
        e.wr = 1'b1;
        e.outcome = OUT_NO_DATA;
      end else begin
        if (r.ch0 < low_thr) begin
          if (low_run < RUN_MAX) low_run++;
          if (low_run >= runs_needed && gain_step < TOP_STEP) begin
            low_run = '0;
            gain_step++;
            e.wr = 1'b1;
            e.outcome = OUT_NO_DATA;
          end
        end else begin
          low_run = '0;
        end
        if (e.outcome == OUT_LUX) e.lux = lux_of(r.ch0, r.ch1, r.code);
      end
      e.mult = MULT_W'(GAIN_FACTOR[r.code]);
      e.vis  = r.ch0;
      e.ir   = r.ch1;
      e.code = STEP_CODE[gain_step];
      expected_q.push_back(e);
    endfunction

    function void cmp(string field, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
      end
    endfunction

    function void check_result(light_result_t got);
      light_result_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with no reading pending, expected none, got lux %0d",
                 $time, got.lux);
        return;
      end
      e = expected_q.pop_front();
      cmp("outcome", e.outcome, got.outcome);
      cmp("lux", e.lux, got.lux);
      cmp("gain_multiplier", e.mult, got.mult);
      cmp("visible_echo", e.vis, got.vis);
      cmp("infrared_echo", e.ir, got.ir);
      cmp("gain_write", e.wr, got.wr);
      cmp("new_gain_code", e.code, got.code);
      if (got.outcome === OUT_LUX) n_lux++;
      if (got.wr === 1'b1) n_writes++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  alag_in_if  in_if ();
  alag_out_if out_if ();

  ambient_light_autogain_lux_core #(
    .GAIN_STEPS (GAIN_STEPS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  light_scoreboard sb = new();
  bit src_idle_on;
  bit snk_idle_on;
  int hold_reqs;
  int n_sent;
  int n_settings;
  int quiet;

  always begin
    clk_i = 1'b1;
    #HALF_PERIOD;
    clk_i = 1'b0;
    #HALF_PERIOD;
  end

  function automatic reading_t mk(bit inv, bit fresh, bit [2:0] code, int unsigned c0,
                                  int unsigned c1);
    reading_t r;
    r.invalid = inv;
    r.fresh   = fresh;
    r.code    = code;
    r.ch0     = CNT_W'(c0);
    r.ch1     = CNT_W'(c1);
    return r;
  endfunction

  // mostly fresh readings steered around the thresholds and the ratio regions
  function automatic reading_t random_reading();
    reading_t r;
    int kind, cls, pct;
    int unsigned c0, c1;
    kind = $urandom_range(0, 99);
    r.invalid = 1'b0;
    r.fresh   = 1'b1;
    if ($urandom_range(0, 9) < 3) r.code = STEP_CODE[sb.gain_step];
    else r.code = CODE_W'($urandom_range(0, 7));
    if (kind < 8) begin
      r.invalid = 1'b1;
      r.fresh   = 1'($urandom_range(0, 1));
    end else if (kind < 16) begin
      r.fresh = 1'b0;
    end
    cls = $urandom_range(0, 99);
    if (cls < 35 && sb.low_thr > 0) c0 = $urandom_range(0, sb.low_thr - 1);
    else if (cls < 50 && sb.high_thr < 16'hFFFF) c0 = $urandom_range(sb.high_thr + 1, 65535);
    else c0 = $urandom_range(0, 65535);
    if ($urandom_range(0, 9) < 3) begin
      c1 = $urandom_range(0, 65535);
    end else begin
      pct = $urandom_range(0, 99);
      c1 = c0 * pct / (100 - pct);
      if (c1 > 65535) c1 = 65535;
    end
    r.ch0 = CNT_W'(c0);
    r.ch1 = CNT_W'(c1);
    return r;
  endfunction

  task automatic send_reading(reading_t r);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid              <= 1'b1;
    in_if.data_invalid       <= r.invalid;
    in_if.data_new           <= r.fresh;
    in_if.measured_gain_code <= r.code;
    in_if.visible_count      <= r.ch0;
    in_if.infrared_count     <= r.ch1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_reading(r);
    n_sent++;
  endtask

  // stop offering and wait for every pending result
  task automatic quiesce();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_config(logic [CFG_W-1:0] hi, logic [CFG_W-1:0] lo,
                              logic [CFG_W-1:0] runs, logic [CFG_W-1:0] integ);
    logic [CFG_W-1:0] vals [4];
    vals[CFG_HIGH_THR] = hi;
    vals[CFG_LOW_THR]  = lo;
    vals[CFG_LOW_RUNS] = runs;
    vals[CFG_INTEG]    = integ;
    cfg_we_i <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_idx_i  <= 2'(k);
      cfg_data_i <= vals[k];
      @(posedge clk_i);
      sb.set_reg(2'(k), vals[k]);
    end
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    n_settings++;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    int holds_done;
    light_result_t got;
    holds_done = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holds_done != hold_reqs) begin
        stall = HOLD_CYCLES;
        holds_done++;
      end else begin
        stall = snk_idle_on ? $urandom_range(0, 16) : 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      got.outcome = alag_outcome_e'(out_if.outcome);
      got.lux     = out_if.lux;
      got.mult    = out_if.gain_multiplier;
      got.vis     = out_if.visible_echo;
      got.ir      = out_if.infrared_echo;
      got.wr      = out_if.gain_write;
      got.code    = out_if.new_gain_code;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding", $time, quiet,
                 sb.pending());
        $display("ambient_light_autogain_lux_core_tb failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] hi, lo, runs, integ;
    rst_ni                   <= 1'b0;
    cfg_we_i                 <= 1'b0;
    cfg_idx_i                <= CFG_HIGH_THR;
    cfg_data_i               <= '0;
    in_if.valid              <= 1'b0;
    in_if.data_invalid       <= 1'b0;
    in_if.data_new           <= 1'b0;
    in_if.measured_gain_code <= '0;
    in_if.visible_count      <= '0;
    in_if.infrared_count     <= '0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    hold_reqs   = 0;
    n_sent      = 0;
    n_settings  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed, reset configuration: gain starts at 8x
    send_reading(mk(0, 0, 3'd3, 1234, 567));       // no new data
    send_reading(mk(1, 1, 3'd3, 65535, 65535));    // invalid wins over new
    send_reading(mk(1, 0, 3'd2, 0, 0));
    send_reading(mk(1, 1, 3'd1, 40000, 100));
    send_reading(mk(1, 1, 3'd0, 100, 40000));      // invalid at lowest gain
    send_reading(mk(0, 1, 3'd0, 0, 0));            // both counts zero
    send_reading(mk(0, 1, 3'd0, 500, 100));
    send_reading(mk(0, 1, 3'd0, 500, 300));        // third low reading steps up
    send_reading(mk(0, 1, 3'd1, 65535, 0));        // above high threshold
    send_reading(mk(0, 1, 3'd7, 65535, 65535));    // lowest gain, no step down
    send_reading(mk(0, 1, 3'd0, 40000, 20000));    // low ratio region
    send_reading(mk(0, 1, 3'd0, 5500, 4500));      // ratio exactly 0.45
    send_reading(mk(0, 1, 3'd1, 10000, 12000));    // middle region
    send_reading(mk(0, 1, 3'd2, 3600, 6400));      // ratio exactly 0.64
    send_reading(mk(0, 1, 3'd3, 10000, 25000));    // upper region
    send_reading(mk(0, 1, 3'd6, 1500, 8500));      // ratio exactly 0.85
    send_reading(mk(0, 1, 3'd7, 1000, 9000));      // above 0.85
    send_reading(mk(0, 1, 3'd4, 30000, 1000));     // unknown gain code
    send_reading(mk(0, 1, 3'd5, 30000, 0));
    send_reading(mk(0, 1, 3'd6, 20000, 5000));
    send_reading(mk(0, 1, 3'd7, 52000, 65535));    // at the high threshold
    send_reading(mk(0, 1, 3'd0, 1000, 0));         // at the low threshold
    quiesce();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin hi = 16'd52000; lo = 16'd1000;  runs = 16'd3;  integ = 16'd2;  end
        1: begin hi = 16'hFFFF;  lo = 16'd0;     runs = 16'd15; integ = 16'd8;  end
        2: begin hi = 16'd0;     lo = 16'hFFFF;  runs = 16'd0;  integ = 16'd0;  end
        3: begin hi = 16'd40000; lo = 16'd20000; runs = 16'd1;  integ = 16'd1;  end
        // almost every reading is low: climb to the top gain, then the run count saturates
        4: begin hi = 16'hFFFF;  lo = 16'hFFFF;  runs = 16'd1;  integ = 16'd15; end
        5: begin hi = 16'd30000; lo = 16'd500;   runs = 16'd7;  integ = 16'd9;  end
        6: begin hi = 16'hFFFF;  lo = 16'hFFFF;  runs = 16'd15; integ = 16'd3;  end
        default: begin
          // stray upper data bits on the narrow registers
          hi    = CFG_W'($urandom_range(0, 65535));
          lo    = CFG_W'($urandom_range(0, 65535));
          runs  = CFG_W'($urandom_range(0, 65535));
          integ = CFG_W'($urandom_range(0, 65535));
        end
      endcase
      apply_config(hi, lo, runs, integ);
      src_idle_on = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      snk_idle_on = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (ph == 3) hold_reqs++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_reading(random_reading());
        if ($urandom_range(0, 49) == 0) quiesce();
      end
      quiesce();
    end

    repeat (60) @(posedge clk_i);
    $display("Sent %0d readings over %0d register settings; checked %0d results.",
             n_sent, n_settings, sb.n_results);
    $display("Results with lux: %0d, gain writes: %0d, mismatches: %0d.",
             sb.n_lux, sb.n_writes, sb.errors);
    if (sb.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ambient_light_autogain_lux_core_tb passed");
    end else begin
      $display("ambient_light_autogain_lux_core_tb failed");
    end
    $finish;
  end

endmodule
